/* sv/aqpr_pkg.sv */
// Package for the aging queue: sizes, command and status codes, entry type.
// No dependencies; used by the command interface, the aging unit and the top level.
package aqpr_pkg;

    localparam int DEPTH  = 16;
    localparam int SERVED = 3;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 5;
    localparam int CMPW   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int LPT_W  = 8;
    localparam int PADDR_W = 3;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_LPT  = 1'b1;

    localparam logic [LPT_W-1:0] LPT_RESET = LPT_W'(10);

    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] lines;
        logic [15:0] wait_cnt;
        logic [15:0] print_cnt;
        logic [15:0] total_cnt;
    } entry_t;

endpackage

/* sv/aqpr_if.sv */
// Command and result channel interfaces of the aging queue.
// Depends on aqpr_pkg for the position width.
interface aqpr_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  command;
    logic [15:0]                 job_tag;
    logic signed [15:0]          job_lines;
    logic [15:0]                 job_wait;
    logic [15:0]                 job_print;
    logic [15:0]                 job_total;
    logic [aqpr_pkg::POS_W-1:0]  position;

    modport source (output valid, command, job_tag, job_lines, job_wait, job_print,
                    job_total, position, input ready);
    modport sink (input valid, command, job_tag, job_lines, job_wait, job_print,
                  job_total, position, output ready);
endinterface

interface aqpr_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [15:0]        out_tag;
    logic signed [15:0] out_lines;
    logic [15:0]        out_wait;
    logic [15:0]        out_print;
    logic [15:0]        out_total;
    logic [4:0]         occupancy_out;
    logic               last;

    modport source (output valid, status, out_tag, out_lines, out_wait, out_print,
                    out_total, occupancy_out, last, input ready);
    modport sink (input valid, status, out_tag, out_lines, out_wait, out_print,
                  out_total, occupancy_out, last, output ready);
endinterface

/* sv/aqpr_age_unit.sv */
// Shared aging unit: ages one queue entry per use (saturating counters,
// lines taken with saturation at the bottom). Depends on aqpr_pkg.
module aqpr_age_unit
(
    input  aqpr_pkg::entry_t                ent_in,
    input  logic                            wait_mode,
    input  logic                            take,
    input  logic [aqpr_pkg::LPT_W-1:0]      lpt,
    output aqpr_pkg::entry_t                ent_out
);

    logic [16:0] diff;
    logic [15:0] lines_taken;
    logic [15:0] wait_inc;
    logic [15:0] print_inc;
    logic [15:0] total_inc;

    assign wait_inc  = (ent_in.wait_cnt  == 16'hFFFF) ? ent_in.wait_cnt  : ent_in.wait_cnt  + 16'd1;
    assign print_inc = (ent_in.print_cnt == 16'hFFFF) ? ent_in.print_cnt : ent_in.print_cnt + 16'd1;
    assign total_inc = (ent_in.total_cnt == 16'hFFFF) ? ent_in.total_cnt : ent_in.total_cnt + 16'd1;

    // sign-extended subtract; bits 16 and 15 differ only on underflow
    assign diff        = {ent_in.lines[15], ent_in.lines} - {{(17-aqpr_pkg::LPT_W){1'b0}}, lpt};
    assign lines_taken = (diff[16] != diff[15]) ? 16'h8000 : diff[15:0];

    always_comb
    begin
        ent_out           = ent_in;
        ent_out.total_cnt = total_inc;
        if (wait_mode)
        begin
            ent_out.wait_cnt = wait_inc;
        end
        else
        begin
            ent_out.print_cnt = print_inc;
            if (take)
            begin
                ent_out.lines = lines_taken;
            end
        end
    end

endmodule

/* sv/aging_queue_positional_removal_core.sv */
// Aging job queue with removal at any position.
// Commands come in as words on the cmd channel (valid/ready); each command
// gives one result word on the res channel, or up to SERVED words for a
// print tick, the final one flagged by last. The block takes one command
// at a time: cmd.ready is high only while the sequencer is idle.
// A remove shifts the entries behind slot k down; a tick walks all N queued
// entries. The walk is one read and one write per entry over the
// single-port entry memory, with one shared aging unit.
// A stalled receiver holds the result register and the sequencer waits at
// the step that produces the next word; nothing is dropped.
// Configuration through the APB port: register 0 (addr 0) mode, 0 print
// aging, 1 wait aging; register 1 (addr 4) lines per print tick. Values
// are latched when a command is taken.
// Reset empties the queue (occupancy 0), sets mode 0 and lines per tick 10.
// Entry storage is not cleared; only occupied slots are ever read.
// Depends on aqpr_pkg, aqpr_if and aqpr_age_unit.
module aging_queue_positional_removal_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    aqpr_cmd_if.sink                          cmd,
    aqpr_res_if.source                        res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [aqpr_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HEAD  = 4'd1;
    localparam logic [3:0] S_HEADW = 4'd2;
    localparam logic [3:0] S_EMIT  = 4'd3;
    localparam logic [3:0] S_RREM  = 4'd4;
    localparam logic [3:0] S_RCAP  = 4'd5;
    localparam logic [3:0] S_SHRD  = 4'd6;
    localparam logic [3:0] S_SHWR  = 4'd7;
    localparam logic [3:0] S_TRD   = 4'd8;
    localparam logic [3:0] S_TWR   = 4'd9;

    localparam int IDX_W = aqpr_pkg::IDX_W;
    localparam int CNT_W = aqpr_pkg::CNT_W;
    localparam int CMPW  = aqpr_pkg::CMPW;
    localparam int LPT_W = aqpr_pkg::LPT_W;

    // configuration
    logic             mode_reg;
    logic [LPT_W-1:0] lpt_reg;
    logic             cfg_wr;

    // sequencer
    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [1:0]       status_reg, status_next;
    logic             mode_op_reg, mode_op_next;
    logic [LPT_W-1:0] lpt_op_reg, lpt_op_next;

    // entry memory
    aqpr_pkg::entry_t mem [aqpr_pkg::DEPTH];
    aqpr_pkg::entry_t rd_data_reg;
    aqpr_pkg::entry_t mem_wdata;
    aqpr_pkg::entry_t in_ent;
    aqpr_pkg::entry_t aged;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    // result register
    aqpr_pkg::entry_t out_ent_reg;
    logic [1:0]       out_status_reg;
    logic [CNT_W-1:0] out_occ_reg;
    logic             out_last_reg;
    logic             out_valid_reg;
    logic             out_free;
    logic             out_load;
    aqpr_pkg::entry_t load_ent;
    logic [1:0]       load_status;
    logic [CNT_W-1:0] load_occ;
    logic             load_last;

    logic             cmd_fire;
    logic [CMPW-1:0]  pos_ext;
    logic [CMPW-1:0]  occ_ext;
    logic [CMPW-1:0]  ptr_ext;
    logic [CMPW-1:0]  served;
    logic             take;
    logic             need_emit;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == aqpr_pkg::REG_LPT) ? {{(32-LPT_W){1'b0}}, lpt_reg}
                                                    : {31'b0, mode_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            lpt_reg  <= aqpr_pkg::LPT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == aqpr_pkg::REG_MODE)
            begin
                mode_reg <= pwdata[0];
            end
            else
            begin
                lpt_reg <= pwdata[LPT_W-1:0];
            end
        end
    end

    // ---------------- shared aging unit ----------------
    assign occ_ext = CMPW'(occ_reg);
    assign ptr_ext = CMPW'(ptr_reg);
    assign pos_ext = CMPW'(cmd.position);
    assign served  = (occ_ext < CMPW'(aqpr_pkg::SERVED)) ? occ_ext : CMPW'(aqpr_pkg::SERVED);
    assign take    = ptr_ext < served;

    aqpr_age_unit u_age
    (
        .ent_in    (rd_data_reg),
        .wait_mode (mode_op_reg),
        .take      (take),
        .lpt       (lpt_op_reg),
        .ent_out   (aged)
    );

    assign in_ent.tag       = cmd.job_tag;
    assign in_ent.lines     = cmd.job_lines;
    assign in_ent.wait_cnt  = cmd.job_wait;
    assign in_ent.print_cnt = cmd.job_print;
    assign in_ent.total_cnt = cmd.job_total;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || res.ready;
    assign need_emit = mode_op_reg ? (ptr_reg == '0) : take;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        ptr_next     = ptr_reg;
        status_next  = status_reg;
        mode_op_next = mode_op_reg;
        lpt_op_next  = lpt_op_reg;
        mem_we       = 1'b0;
        mem_waddr    = ptr_reg;
        mem_wdata    = rd_data_reg;
        rd_en        = 1'b0;
        rd_addr      = ptr_reg;
        out_load     = 1'b0;
        load_ent     = '0;
        load_status  = status_reg;
        load_occ     = occ_reg;
        load_last    = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    mode_op_next = mode_reg;
                    lpt_op_next  = lpt_reg;
                    case (cmd.command)
                        aqpr_pkg::CMD_INSERT:
                        begin
                            if (occ_reg < CNT_W'(aqpr_pkg::DEPTH))
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = occ_reg[IDX_W-1:0];
                                mem_wdata   = in_ent;
                                occ_next    = occ_reg + CNT_W'(1);
                                status_next = aqpr_pkg::ST_OK;
                            end
                            else
                            begin
                                status_next = aqpr_pkg::ST_FULL;
                            end
                            state_next = S_HEAD;
                        end
                        aqpr_pkg::CMD_REMOVE:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = aqpr_pkg::ST_EMPTY;
                                state_next  = S_EMIT;
                            end
                            else if (pos_ext > occ_ext)
                            begin
                                status_next = aqpr_pkg::ST_RANGE;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                status_next = aqpr_pkg::ST_OK;
                                ptr_next    = (pos_ext == '0) ? '0 : IDX_W'(pos_ext - CMPW'(1));
                                state_next  = S_RREM;
                            end
                        end
                        aqpr_pkg::CMD_TICK:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = aqpr_pkg::ST_EMPTY;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                status_next = aqpr_pkg::ST_OK;
                                ptr_next    = '0;
                                state_next  = S_TRD;
                            end
                        end
                        default:
                        begin
                            status_next = aqpr_pkg::ST_OK;
                            state_next  = (occ_reg == '0) ? S_EMIT : S_HEAD;
                        end
                    endcase
                end
            end
            S_HEAD:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_HEADW;
            end
            S_HEADW:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_ent   = rd_data_reg;
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RREM:
            begin
                rd_en      = 1'b1;
                state_next = S_RCAP;
            end
            S_RCAP:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    load_ent = rd_data_reg;
                    load_occ = occ_reg - CNT_W'(1);
                    if (ptr_ext + CMPW'(1) < occ_ext)
                    begin
                        state_next = S_SHRD;
                    end
                    else
                    begin
                        occ_next   = occ_reg - CNT_W'(1);
                        state_next = S_IDLE;
                    end
                end
            end
            S_SHRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = ptr_reg + IDX_W'(1);
                state_next = S_SHWR;
            end
            S_SHWR:
            begin
                // close the gap: entry ptr+1 moves down to ptr
                mem_we   = 1'b1;
                ptr_next = ptr_reg + IDX_W'(1);
                if (ptr_ext + CMPW'(2) < occ_ext)
                begin
                    state_next = S_SHRD;
                end
                else
                begin
                    occ_next   = occ_reg - CNT_W'(1);
                    state_next = S_IDLE;
                end
            end
            S_TRD:
            begin
                rd_en      = 1'b1;
                state_next = S_TWR;
            end
            S_TWR:
            begin
                if (!need_emit || out_free)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = aged;
                    if (need_emit)
                    begin
                        out_load  = 1'b1;
                        load_ent  = aged;
                        load_last = mode_op_reg || (ptr_ext + CMPW'(1) == served);
                    end
                    ptr_next = ptr_reg + IDX_W'(1);
                    if (ptr_ext + CMPW'(1) < occ_ext)
                    begin
                        state_next = S_TRD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            ptr_reg     <= '0;
            status_reg  <= aqpr_pkg::ST_OK;
            mode_op_reg <= 1'b0;
            lpt_op_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            ptr_reg     <= ptr_next;
            status_reg  <= status_next;
            mode_op_reg <= mode_op_next;
            lpt_op_reg  <= lpt_op_next;
        end
    end

    // ---------------- entry memory ----------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ent_reg    <= load_ent;
            out_status_reg <= load_status;
            out_occ_reg    <= load_occ;
            out_last_reg   <= load_last;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.status        = out_status_reg;
    assign res.out_tag       = out_ent_reg.tag;
    assign res.out_lines     = $signed(out_ent_reg.lines);
    assign res.out_wait      = out_ent_reg.wait_cnt;
    assign res.out_print     = out_ent_reg.print_cnt;
    assign res.out_total     = out_ent_reg.total_cnt;
    assign res.occupancy_out = 5'(out_occ_reg);
    assign res.last          = out_last_reg;

    // ---------------- assertions ----------------
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(aqpr_pkg::DEPTH))
        else $error("occupancy above depth");

    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg != $past(occ_reg)) |->
        (occ_reg == $past(occ_reg) + CNT_W'(1) || occ_reg + CNT_W'(1) == $past(occ_reg)))
        else $error("occupancy moved by more than one");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TWR || state_reg == S_SHWR || state_reg == S_RCAP) |-> ptr_ext < occ_ext)
        else $error("walk pointer past occupied slots");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |-> !out_load)
        else $error("result register overwritten while stalled");

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// Testbench for aging_queue_positional_removal_core: a scoreboard class predicts the result
// words of every accepted command, and directed plus random commands run under several configs.
// Depends on aqpr_pkg, aqpr_if and the core RTL.
module tb;

    localparam int                           PADDR_W     = aqpr_pkg::PADDR_W;
    localparam int                           POS_W       = aqpr_pkg::POS_W;
    localparam logic [1:0]                   CMD_UNUSED  = 2'd3;
    localparam logic [PADDR_W-1:0]           ADDR_MODE   = {aqpr_pkg::REG_MODE, 2'b00};
    localparam logic [PADDR_W-1:0]           ADDR_LPT    = {aqpr_pkg::REG_LPT, 2'b00};
    localparam int                           QUIET_LIMIT = 3000;
    localparam int                           HOLD_CYCLES = 400;

    typedef struct packed {
        logic [1:0]       command;
        aqpr_pkg::entry_t job;
        logic [POS_W-1:0] position;
    } job_cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        aqpr_pkg::entry_t ent;
        logic [4:0]       occ;
        logic             last;
    } result_word_t;

    class job_queue_scoreboard;
        aqpr_pkg::entry_t slots[$];
        logic             mode;
        logic [7:0]       lines_per_tick;
        result_word_t     expected_words[$];
        int               errors;

        function new();
            mode = 1'b0;
            lines_per_tick = aqpr_pkg::LPT_RESET;
            errors = 0;
        endfunction

        function int occupancy();
            return slots.size();
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void set_reg(logic [PADDR_W-1:0] addr, logic [31:0] data);
            if (addr == ADDR_MODE)
                mode = data[0];
            else
                lines_per_tick = data[7:0];
        endfunction

        function logic [31:0] reg_value(logic [PADDR_W-1:0] addr);
            return (addr == ADDR_MODE) ? 32'(mode) : 32'(lines_per_tick);
        endfunction

        function logic [15:0] bump(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function void push_word(logic [1:0] status, aqpr_pkg::entry_t ent, logic last);
            result_word_t w;
            w.status = status;
            w.ent    = ent;
            w.occ    = 5'(slots.size());
            w.last   = last;
            expected_words.push_back(w);
        endfunction

        function void note_command(job_cmd_t c);
            aqpr_pkg::entry_t e;
            aqpr_pkg::entry_t none;
            int               idx;
            int               served;
            int               v;
            none = '0;
            case (c.command)
                aqpr_pkg::CMD_INSERT:
                    if (slots.size() >= aqpr_pkg::DEPTH)
                        push_word(aqpr_pkg::ST_FULL, slots[0], 1'b1);
                    else
                    begin
                        slots.push_back(c.job);
                        push_word(aqpr_pkg::ST_OK, slots[0], 1'b1);
                    end
                aqpr_pkg::CMD_REMOVE:
                    if (slots.size() == 0)
                        push_word(aqpr_pkg::ST_EMPTY, none, 1'b1);
                    else if (int'(c.position) > slots.size())
                        push_word(aqpr_pkg::ST_RANGE, none, 1'b1);
                    else
                    begin
                        // 0 and 1 both pick the head
                        idx = (c.position == 0) ? 0 : int'(c.position) - 1;
                        e = slots[idx];
                        slots.delete(idx);
                        push_word(aqpr_pkg::ST_OK, e, 1'b1);
                    end
                aqpr_pkg::CMD_TICK:
                    if (slots.size() == 0)
                        push_word(aqpr_pkg::ST_EMPTY, none, 1'b1);
                    else if (mode == 1'b0)
                    begin
                        served = (slots.size() < aqpr_pkg::SERVED) ? slots.size()
                                                                   : aqpr_pkg::SERVED;
                        for (int i = 0; i < slots.size(); i++)
                        begin
                            e = slots[i];
                            e.print_cnt = bump(e.print_cnt);
                            e.total_cnt = bump(e.total_cnt);
                            if (i < served)
                            begin
                                v = int'($signed(e.lines)) - int'(lines_per_tick);
                                e.lines = (v < -32768) ? 16'h8000 : v[15:0];
                            end
                            slots[i] = e;
                        end
                        for (int i = 0; i < served; i++)
                            push_word(aqpr_pkg::ST_OK, slots[i], i == served - 1);
                    end
                    else
                    begin
                        for (int i = 0; i < slots.size(); i++)
                        begin
                            e = slots[i];
                            e.wait_cnt  = bump(e.wait_cnt);
                            e.total_cnt = bump(e.total_cnt);
                            slots[i] = e;
                        end
                        push_word(aqpr_pkg::ST_OK, slots[0], 1'b1);
                    end
                default:
                    push_word(aqpr_pkg::ST_OK, (slots.size() != 0) ? slots[0] : none, 1'b1);
            endcase
        endfunction

        function void field_check(string what, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_word(result_word_t got);
            result_word_t want;
            if (expected_words.size() == 0)
            begin
                $display("%0t: result word with none expected: status %0d tag %h",
                         $time, got.status, got.ent.tag);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            field_check("status", 16'(want.status), 16'(got.status));
            field_check("out_tag", want.ent.tag, got.ent.tag);
            field_check("out_lines", want.ent.lines, got.ent.lines);
            field_check("out_wait", want.ent.wait_cnt, got.ent.wait_cnt);
            field_check("out_print", want.ent.print_cnt, got.ent.print_cnt);
            field_check("out_total", want.ent.total_cnt, got.ent.total_cnt);
            field_check("occupancy_out", 16'(want.occ), 16'(got.occ));
            field_check("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    aqpr_cmd_if cmd_ch();
    aqpr_res_if res_ch();

    job_queue_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_len      = 0;
    int hold_seq      = 0;
    int quiet_cycles  = 0;

    aging_queue_positional_removal_core dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // receiver: random stalls, plus a long hold-off when requested
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_word('{status: res_ch.status,
                            ent: '{tag: res_ch.out_tag, lines: res_ch.out_lines,
                                   wait_cnt: res_ch.out_wait, print_cnt: res_ch.out_print,
                                   total_cnt: res_ch.out_total},
                            occ: res_ch.occupancy_out, last: res_ch.last});
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [15:0] rand_count();
        case ($urandom_range(4))
            0:       return 16'hFFFF - 16'($urandom_range(3));
            1:       return 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_lines();
        case ($urandom_range(4))
            0:       return 16'h8000 + 16'($urandom_range(300));
            1:       return 16'h7FFF - 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    // fill mode leans on inserts so the queue reaches full
    function automatic job_cmd_t make_job(int occ, bit fill);
        job_cmd_t c;
        int       pick;
        int       ins;
        int       rem;
        c.job.tag       = 16'($urandom);
        c.job.lines     = rand_lines();
        c.job.wait_cnt  = rand_count();
        c.job.print_cnt = rand_count();
        c.job.total_cnt = rand_count();
        c.position      = POS_W'($urandom_range(31));
        ins  = fill ? 70 : ((occ < 4) ? 50 : 35);
        rem  = fill ? 15 : 30;
        pick = $urandom_range(99);
        if (pick < ins)
            c.command = aqpr_pkg::CMD_INSERT;
        else if (pick < ins + rem)
        begin
            c.command = aqpr_pkg::CMD_REMOVE;
            if ($urandom_range(9) != 0)
                c.position = POS_W'($urandom_range(occ + 1));
        end
        else if (pick < 97)
            c.command = aqpr_pkg::CMD_TICK;
        else
            c.command = CMD_UNUSED;
        return c;
    endfunction

    task automatic send_job(job_cmd_t c);
        cmd_ch.valid     <= 1'b1;
        cmd_ch.command   <= c.command;
        cmd_ch.job_tag   <= c.job.tag;
        cmd_ch.job_lines <= c.job.lines;
        cmd_ch.job_wait  <= c.job.wait_cnt;
        cmd_ch.job_print <= c.job.print_cnt;
        cmd_ch.job_total <= c.job.total_cnt;
        cmd_ch.position  <= c.position;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        sb.note_command(c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_insert(logic [15:0] tag, logic [15:0] lines, logic [15:0] wcnt,
                               logic [15:0] pcnt, logic [15:0] tcnt);
        job_cmd_t c;
        c.command = aqpr_pkg::CMD_INSERT;
        c.job     = '{tag: tag, lines: lines, wait_cnt: wcnt, print_cnt: pcnt, total_cnt: tcnt};
        c.position = POS_W'($urandom_range(31));
        send_job(c);
    endtask

    task automatic send_ctl(logic [1:0] command, logic [POS_W-1:0] position);
        job_cmd_t c;
        c = make_job(0, 1'b0);
        c.command  = command;
        c.position = position;
        send_job(c);
    endtask

    // wait for every expected word and for the sequencer to go idle
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (sb.pending() != 0 || !cmd_ch.ready)
            @(posedge clk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(addr, data);
        @(posedge clk);
    endtask

    task automatic apb_read_check(logic [PADDR_W-1:0] addr);
        logic [31:0] want;
        logic [31:0] got;
        want = sb.reg_value(addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
        begin
            $display("%0t: register %0d readback mismatch: expected %h, got %h",
                     $time, addr, want, got);
            sb.errors++;
        end
        @(posedge clk);
    endtask

    task automatic set_config(logic mode, logic [7:0] lpt);
        apb_write(ADDR_MODE, 32'(mode));
        apb_read_check(ADDR_MODE);
        apb_write(ADDR_LPT, 32'(lpt));
        apb_read_check(ADDR_LPT);
    endtask

    task automatic run_phase(logic mode, logic [7:0] lpt, int idle_pct, int stall,
                             int count, bit fill);
        set_config(mode, lpt);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        repeat (count)
            send_job(make_job(sb.occupancy(), fill));
        drain();
    endtask

    initial
    begin
        sb = new();
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.command   = aqpr_pkg::CMD_INSERT;
        cmd_ch.job_tag   = '0;
        cmd_ch.job_lines = '0;
        cmd_ch.job_wait  = '0;
        cmd_ch.job_print = '0;
        cmd_ch.job_total = '0;
        cmd_ch.position  = '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_read_check(ADDR_MODE);
        apb_read_check(ADDR_LPT);

        // directed, reset config: commands on the empty queue first
        send_ctl(aqpr_pkg::CMD_TICK, 0);
        send_ctl(aqpr_pkg::CMD_REMOVE, 0);
        send_ctl(CMD_UNUSED, 31);
        // lines near the floor, counters near the top
        send_insert(16'h0000, 16'h8005, 16'h0000, 16'hFFFE, 16'hFFFF);
        send_insert(16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h0000, 16'hFFFE);
        send_insert(16'h1234, 16'h0000, 16'h0001, 16'h0002, 16'h0003);
        send_ctl(aqpr_pkg::CMD_TICK, 0);
        send_ctl(aqpr_pkg::CMD_TICK, 0);
        send_insert(16'hA5A5, 16'hFFFF, 16'h5A5A, 16'hA5A5, 16'h5A5A);
        send_insert(16'h5A5A, 16'h0001, 16'hA5A5, 16'h5A5A, 16'hA5A5);
        // five queued, only three served
        send_ctl(aqpr_pkg::CMD_TICK, 0);
        send_ctl(CMD_UNUSED, 0);
        send_ctl(aqpr_pkg::CMD_REMOVE, 31);
        send_ctl(aqpr_pkg::CMD_REMOVE, 6);
        send_ctl(aqpr_pkg::CMD_REMOVE, 5);
        send_ctl(aqpr_pkg::CMD_REMOVE, 2);
        send_ctl(aqpr_pkg::CMD_REMOVE, 1);
        send_ctl(aqpr_pkg::CMD_REMOVE, 0);
        send_ctl(aqpr_pkg::CMD_REMOVE, 0);
        send_ctl(aqpr_pkg::CMD_REMOVE, 1);
        send_insert(16'h0F0F, 16'h0009, 16'h00FF, 16'hFF00, 16'h0F0F);
        send_ctl(aqpr_pkg::CMD_TICK, 0);
        send_insert(16'hF0F0, 16'h8000, 16'hFF00, 16'h00FF, 16'hF0F0);
        send_ctl(aqpr_pkg::CMD_TICK, 0);
        drain();

        // receiver holds off while commands keep coming
        set_config(1'b0, 8'd255);
        hold_len = HOLD_CYCLES;
        hold_seq++;
        repeat (10)
            send_job(make_job(sb.occupancy(), 1'b1));
        drain();

        run_phase(1'b0, 8'd255, 0, 0, 45, 1'b1);
        run_phase(1'b1, 8'd0, 76, 0, 40, 1'b0);
        run_phase(1'b0, 8'd0, 0, 76, 40, 1'b0);
        run_phase(1'b1, 8'd255, 16, 16, 40, 1'b1);
        run_phase(1'b0, 8'd1, 76, 0, 30, 1'b0);
        run_phase(1'b0, 8'($urandom_range(255)), 0, 76, 35, 1'b0);

        repeat (40)
            @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
sv/aqpr_pkg.sv
sv/aqpr_if.sv
sv/aqpr_age_unit.sv
sv/aging_queue_positional_removal_core.sv
dv/tb.sv
